// File: rtl/core/khrb_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard report builder package
// Shared constants, command and report types for the report builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package khrb_pkg;

  localparam int NUM_KEYS     = 5;
  localparam int REPORT_SLOTS = 6;
  localparam int CODE_SPACE   = 256;

  localparam int KEY_REGS   = 5;
  localparam int ALL_SLOTS  = 6;
  localparam int ACT_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int LEVELS_W   = 5;
  localparam int S_DATA_W   = 8;
  localparam int M_DATA_W   = 8 * (ALL_SLOTS + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ROWS   = (CODE_SPACE + 7) / 8;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = $clog2(ALL_SLOTS + 1);

  localparam logic [KEY_REGS-1:0][ACT_W-1:0] ACTION_RESET = {
    9'd8, 9'd7, 9'd6, 9'd260, 9'd257
  };

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic                report;
    logic [NUM_KEYS-1:0] chg;
    logic [NUM_KEYS-1:0] lvl;
  } cmd_t;

  typedef struct packed {
    logic [ALL_SLOTS-1:0][7:0] slot;
    logic [7:0]                modifier;
  } report_t;

endpackage

`default_nettype wire

// File: rtl/core/khrb_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short queue of classified commands between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module khrb_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire khrb_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output khrb_pkg::cmd_t       pop_cmd
);

  khrb_pkg::cmd_t                 entry [khrb_pkg::QDEPTH];
  logic [khrb_pkg::QPTR_W-1:0]    wptr;
  logic [khrb_pkg::QPTR_W-1:0]    rptr;
  logic [khrb_pkg::QPTR_W:0]      count;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count == (khrb_pkg::QPTR_W + 1)'(khrb_pkg::QDEPTH));
  assign valid   = (count != '0);
  assign pop_cmd = entry[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/khrb_front.sv
// ----------------------------------------------------------------------------
// Input front end
// Accepts input transactions, tracks key levels and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module khrb_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [khrb_pkg::S_DATA_W-1:0] s_tdata,
  input  wire logic                          s_tuser,
  input  wire logic                          q_full,
  output logic                               push,
  output khrb_pkg::cmd_t                     push_cmd
);

  logic [khrb_pkg::NUM_KEYS-1:0] key_down;
  logic [khrb_pkg::NUM_KEYS-1:0] levels;
  logic                          host_ready;
  logic                          accept;
  logic                          is_sample;

  assign s_tready   = !q_full;
  assign accept     = s_tvalid && s_tready;
  assign levels     = s_tdata[khrb_pkg::NUM_KEYS-1:0];
  assign host_ready = s_tdata[khrb_pkg::LEVELS_W];
  assign is_sample  = (s_tuser == khrb_pkg::FUNC_SAMPLE);

  always_comb begin
    push_cmd.report = !is_sample;
    push_cmd.chg    = is_sample ? (levels ^ key_down) : '0;
    push_cmd.lvl    = levels;
    push = accept && (is_sample ? (push_cmd.chg != '0) : host_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down <= '0;
    end else if (accept && is_sample) begin
      key_down <= levels;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/khrb_back.sv
// ----------------------------------------------------------------------------
// Command back end
// Applies key actions to the modifier byte and the active code memory,
// and scans the memory one row of eight codes per cycle to build reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module khrb_back (
  input  wire logic                                              clk,
  input  wire logic                                              rst,
  input  wire logic [khrb_pkg::NUM_KEYS-1:0][khrb_pkg::ACT_W-1:0] actions,
  input  wire logic                                              q_valid,
  input  wire khrb_pkg::cmd_t                                    q_cmd,
  output logic                                                   q_pop,
  output logic                                                   m_tvalid,
  input  wire logic                                              m_tready,
  output logic [khrb_pkg::M_DATA_W-1:0]                          m_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEY  = 2'd1;
  localparam logic [1:0] ST_KWR  = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  localparam logic [khrb_pkg::KEY_W-1:0]  LAST_KEY  = khrb_pkg::KEY_W'(khrb_pkg::NUM_KEYS - 1);
  localparam logic [khrb_pkg::ROW_W:0]    ROW_COUNT = (khrb_pkg::ROW_W + 1)'(khrb_pkg::ROWS);
  localparam logic [khrb_pkg::SLOT_W-1:0] SLOT_MAX  =
    khrb_pkg::SLOT_W'(khrb_pkg::REPORT_SLOTS);

  logic [1:0]                                state;
  logic [khrb_pkg::KEY_W-1:0]                key;
  khrb_pkg::cmd_t                            cmd;
  logic [khrb_pkg::ROW_W-1:0]                row;
  logic [2:0]                                bitsel;
  logic                                      press;
  logic [khrb_pkg::ROW_W:0]                  issue;
  logic                                      proc_valid;
  logic [khrb_pkg::ROW_W-1:0]                proc_row;
  logic [khrb_pkg::SLOT_W-1:0]               fill;
  logic [khrb_pkg::ALL_SLOTS-1:0][7:0]       slots;
  logic [7:0]                                modifier;
  logic                                      out_valid;
  khrb_pkg::report_t                         out_data;

  logic [7:0]                                mem [khrb_pkg::ROWS];
  logic [khrb_pkg::ROWS-1:0]                 row_valid;
  logic [7:0]                                rd_data;
  logic                                      rd_live;
  logic                                      rd_en;
  logic [khrb_pkg::ROW_W-1:0]                rd_addr;
  logic                                      we;
  logic [7:0]                                wdata;
  logic [7:0]                                row_data;

  logic [khrb_pkg::ACT_W-1:0]                act;
  logic [7:0]                                code;
  logic                                      is_mod;
  logic                                      in_range;
  logic                                      key_chg;
  logic                                      key_needs_mem;
  logic                                      last_key;
  logic [khrb_pkg::ROW_W-1:0]                code_row;
  logic                                      issue_done;
  logic                                      full;
  logic                                      scan_end;
  logic                                      out_load;
  logic [khrb_pkg::ALL_SLOTS-1:0][7:0]       m_slots;
  logic [khrb_pkg::SLOT_W-1:0]               m_fill;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign row_data = rd_live ? rd_data : 8'd0;

  always_comb begin
    act           = actions[key];
    code          = act[7:0];
    is_mod        = act[khrb_pkg::ACT_W-1];
    in_range      = ({1'b0, code} < 9'(khrb_pkg::CODE_SPACE));
    key_chg       = cmd.chg[key];
    key_needs_mem = key_chg && !is_mod && in_range;
    last_key      = (key == LAST_KEY);
    code_row      = khrb_pkg::ROW_W'(code >> 3);
    issue_done    = (issue == ROW_COUNT);
    full          = (fill == SLOT_MAX);
    scan_end      = (issue_done || full) && !proc_valid;
    out_load      = (state == ST_SCAN) && scan_end && (!out_valid || m_tready);

    rd_en   = 1'b0;
    rd_addr = issue[khrb_pkg::ROW_W-1:0];
    unique case (state)
      ST_KEY: begin
        rd_en   = key_needs_mem;
        rd_addr = code_row;
      end
      ST_SCAN: begin
        rd_en = !issue_done && !full;
      end
      default: begin
      end
    endcase

    we             = (state == ST_KWR);
    wdata          = row_data;
    wdata[bitsel]  = press;

    m_slots = slots;
    m_fill  = fill;
    for (int b = 0; b < 8; b++) begin
      if (proc_valid && row_data[b] && (m_fill < SLOT_MAX)) begin
        m_slots[m_fill] = 8'({proc_row, 3'(b)});
        m_fill          = m_fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[row] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_live <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      key        <= '0;
      issue      <= '0;
      proc_valid <= 1'b0;
      fill       <= '0;
      modifier   <= 8'd0;
      out_valid  <= 1'b0;
      row_valid  <= '0;
    end else begin
      proc_valid <= rd_en && (state == ST_SCAN);
      proc_row   <= issue[khrb_pkg::ROW_W-1:0];
      if (we) begin
        row_valid[row] <= 1'b1;
      end
      if (out_load) begin
        out_valid         <= 1'b1;
        out_data.slot     <= slots;
        out_data.modifier <= modifier;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            key   <= '0;
            issue <= '0;
            fill  <= '0;
            slots <= '0;
            state <= q_cmd.report ? ST_SCAN : ST_KEY;
          end
        end
        ST_KEY: begin
          if (key_needs_mem) begin
            row    <= code_row;
            bitsel <= code[2:0];
            press  <= cmd.lvl[key];
            state  <= ST_KWR;
          end else begin
            if (key_chg && is_mod) begin
              modifier <= cmd.lvl[key] ? (modifier | code) : (modifier & ~code);
            end
            if (last_key) begin
              state <= ST_IDLE;
            end else begin
              key <= key + 1'b1;
            end
          end
        end
        ST_KWR: begin
          if (last_key) begin
            state <= ST_IDLE;
          end else begin
            key   <= key + 1'b1;
            state <= ST_KEY;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue <= issue + 1'b1;
          end
          slots <= m_slots;
          fill  <= m_fill;
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= SLOT_MAX)
    else $error("report fill count beyond slot limit");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KWR) |-> ($past(state) == ST_KEY) && $past(rd_en))
    else $error("row write without a preceding row read");

  a_proc_from_scan: assert property (@(posedge clk) disable iff (rst)
    proc_valid |-> ($past(state) == ST_SCAN) && $past(rd_en))
    else $error("row merged without a scan read");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("finished report not presented");

  a_mod_during_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> $stable(modifier))
    else $error("modifier byte changed during a report scan");
`endif

endmodule

`default_nettype wire

// File: rtl/core/keyboard_hid_report_builder.sv
// Operation: a sample holds the back end for one key step per key plus a memory write step
// per changed keycode key; after a tick, m_tvalid for the report rises once the scan of the
// ROWS memory rows (32 with 256 codes) is done, earlier once six active codes are found.
// Throughput: a report scan reads one memory row of eight codes per cycle.
// Reset is synchronous and active high; the active code memory is cleared at once
// through per-row valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
// Keyboard HID report builder
// Top level: action registers, input front end, command queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyboard_hid_report_builder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // key_levels [4:0], host_ready [5], zero [7:6]
  input  wire logic [khrb_pkg::S_DATA_W-1:0]   s_tdata,
  // func [0]
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // modifier_byte [7:0], slot0 [15:8], slot1 [23:16], slot2 [31:24],
  // slot3 [39:32], slot4 [47:40], slot5 [55:48]
  output logic [khrb_pkg::M_DATA_W-1:0]        m_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [khrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [khrb_pkg::ACT_W-1:0]      cfg_data
);

  logic [khrb_pkg::KEY_REGS-1:0][khrb_pkg::ACT_W-1:0] actions;
  logic                                               push;
  khrb_pkg::cmd_t                                     push_cmd;
  logic                                               q_full;
  logic                                               q_valid;
  logic                                               q_pop;
  khrb_pkg::cmd_t                                     q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      actions <= khrb_pkg::ACTION_RESET;
    end else if (cfg_valid && cfg_ready &&
                 ({1'b0, cfg_index} < (khrb_pkg::CFG_IDX_W + 1)'(khrb_pkg::KEY_REGS))) begin
      actions[cfg_index] <= cfg_data;
    end
  end

  khrb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  khrb_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  khrb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .actions  (actions[khrb_pkg::NUM_KEYS-1:0]),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
